### hdl/postfix_stack_evaluator_unit_macros.svh
// Assertion macros for the postfix stack evaluator.
// Expects a clock named clk and an active-high reset named rst in scope.
`ifndef POSTFIX_STACK_EVALUATOR_UNIT_MACROS_SVH
`define POSTFIX_STACK_EVALUATOR_UNIT_MACROS_SVH

// Check that a condition holds on every clock edge outside reset.
`define PSE_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Check that the consequent holds in the same cycle as the antecedent.
`define PSE_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define PSE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/pse_pkg.sv
// Shared types, constants and helpers for the postfix stack evaluator.
// No dependencies; imported by the top level.
package pse_pkg;

  localparam int DATA_W   = 32;
  localparam int OPCODE_W = 3;
  localparam int STATUS_W = 3;
  localparam int DEPTH_W  = 7;
  localparam int ITER_W   = 5;
  localparam int S_DATA_W = 40;
  localparam int M_DATA_W = 48;

  typedef enum logic [OPCODE_W-1:0] {
    OP_PUSH   = 3'd0,
    OP_ADD    = 3'd1,
    OP_SUB    = 3'd2,
    OP_MUL    = 3'd3,
    OP_DIV    = 3'd4,
    OP_FINISH = 3'd5
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK           = 3'd0,
    ST_UNDERFLOW    = 3'd1,
    ST_OVERFLOW     = 3'd2,
    ST_DIV_ZERO     = 3'd3,
    ST_FINISH_COUNT = 3'd4
  } status_t;

  // Absolute value of a two's complement word, read as unsigned.
  function automatic logic [DATA_W-1:0] magnitude(input logic [DATA_W-1:0] v);
    magnitude = v[DATA_W-1] ? (~v + {{(DATA_W-1){1'b0}}, 1'b1}) : v;
  endfunction

endpackage

### hdl/postfix_stack_evaluator_unit.sv
// Postfix stack evaluator: operand stack memory, token sequencer and one
// shared 33-bit adder that serves add, subtract, shift-add multiply and
// restoring divide. Depends on pse_pkg and the evaluator macros header.
//
// One token is taken at a time; s_axis_tready is high only while the block
// is idle and the previous result has been transferred. Push, finish, faults
// and ignored opcodes go from the accepting cycle straight to the result
// state; add and subtract pass through an execute state, multiply and divide
// also through an iterating state, and a negative quotient through a fix-up
// state. The shared adder retires one multiplier or quotient bit per cycle.
// The top of stack is held in a register, so each operator needs only one
// read of the stack memory, issued on the input transfer. No clearing pass
// follows reset: entries above the count are never read.
`include "postfix_stack_evaluator_unit_macros.svh"

module postfix_stack_evaluator_unit #(
  parameter int STACK_DEPTH = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [2:0] opcode, [34:3] operand_value, [39:35] zero
  input  logic [pse_pkg::S_DATA_W-1:0]  s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [31:0] top_value, [34:32] status, [41:35] depth_after, [47:42] zero
  output logic [pse_pkg::M_DATA_W-1:0]  m_axis_tdata
);
  import pse_pkg::*;

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_EXEC = 6'b000010,
    S_MUL  = 6'b000100,
    S_DIV  = 6'b001000,
    S_FIX  = 6'b010000,
    S_RESP = 6'b100000
  } state_t;

  state_t               state, state_next;
  logic [CW-1:0]        count, count_next;
  logic [DATA_W-1:0]    top, top_next;
  status_t              status_next;
  logic                 finish_ok, goto_exec;

  opcode_t              in_op, op;
  logic [DATA_W-1:0]    in_val;
  logic                 accept, full, has_two;
  logic [CW-1:0]        count_m2;
  logic [AW-1:0]        rd_idx;

  logic [DATA_W-1:0]    stack_mem [STACK_DEPTH];
  logic [DATA_W-1:0]    mem_rd;
  logic                 mem_we;
  logic [AW-1:0]        mem_widx;
  logic [DATA_W-1:0]    mem_wdata;

  logic [DATA_W:0]      add_x, add_y, add_sum;
  logic                 add_sub;
  logic [DATA_W-1:0]    rem, den, quo;
  logic [ITER_W-1:0]    iter;
  logic                 neg;
  logic                 div_ok;
  logic [DATA_W-1:0]    rem_step, quo_step, acc_step;

  logic                 commit;
  logic [DATA_W-1:0]    res;

  logic [DATA_W-1:0]    out_top, out_top_next;
  status_t              out_status;
  logic [DEPTH_W-1:0]   out_depth;
  logic [CW+DEPTH_W-1:0] depth_ext, count_ext;
  logic [DEPTH_W-1:0]   depth7_next, count7;

  // Unpack the input transfer
  assign in_op    = opcode_t'(s_axis_tdata[OPCODE_W-1:0]);
  assign in_val   = s_axis_tdata[OPCODE_W+DATA_W-1:OPCODE_W];
  assign accept   = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = (state == S_RESP);
  assign m_axis_tdata  = {{(M_DATA_W-DEPTH_W-STATUS_W-DATA_W){1'b0}},
                          out_depth, out_status, out_top};

  // Stack occupancy and the address of the second entry from the top
  assign full     = (count >= CW'(STACK_DEPTH));
  assign has_two  = (count >= CW'(2));
  assign count_m2 = count - CW'(2);
  assign rd_idx   = count_m2[AW-1:0];

  // Shared adder operand selection
  always_comb begin
    add_x   = '0;
    add_y   = '0;
    add_sub = 1'b0;
    unique case (state)
      S_EXEC: begin
        add_x   = {1'b0, mem_rd};
        add_y   = {1'b0, top};
        add_sub = (op == OP_SUB);
      end
      S_MUL: begin
        add_x = {1'b0, rem};
        add_y = {1'b0, den};
      end
      S_DIV: begin
        add_x   = {rem, quo[DATA_W-1]};
        add_y   = {1'b0, den};
        add_sub = 1'b1;
      end
      S_FIX: begin
        add_y   = {1'b0, quo};
        add_sub = 1'b1;
      end
      default: ;
    endcase
  end

  assign add_sum = add_x + (add_y ^ {(DATA_W+1){add_sub}}) + {{DATA_W{1'b0}}, add_sub};

  // One restoring divide step and one shift-add multiply step
  assign div_ok   = !add_sum[DATA_W];
  assign rem_step = div_ok ? add_sum[DATA_W-1:0] : add_x[DATA_W-1:0];
  assign quo_step = {quo[DATA_W-2:0], div_ok};
  assign acc_step = quo[0] ? add_sum[DATA_W-1:0] : rem;

  // Operator result ready to be written back
  always_comb begin
    commit = 1'b0;
    res    = add_sum[DATA_W-1:0];
    unique case (state)
      S_EXEC: commit = (op == OP_ADD) || (op == OP_SUB);
      S_MUL: begin
        commit = (iter == '0);
        res    = acc_step;
      end
      S_DIV: begin
        commit = (iter == '0) && !neg;
        res    = quo_step;
      end
      S_FIX:   commit = 1'b1;
      default: ;
    endcase
  end

  // Work out stack count, top and status after this step
  always_comb begin
    count_next  = count;
    top_next    = top;
    status_next = ST_OK;
    finish_ok   = 1'b0;
    goto_exec   = 1'b0;
    if (commit) begin
      count_next = count - CW'(1);
      top_next   = res;
    end else if (accept) begin
      unique case (in_op)
        OP_PUSH: begin
          if (full) begin
            status_next = ST_OVERFLOW;
          end else begin
            count_next = count + CW'(1);
            top_next   = in_val;
          end
        end
        OP_ADD, OP_SUB, OP_MUL: begin
          if (!has_two) status_next = ST_UNDERFLOW;
          else          goto_exec   = 1'b1;
        end
        OP_DIV: begin
          if (!has_two)        status_next = ST_UNDERFLOW;
          else if (top == '0)  status_next = ST_DIV_ZERO;
          else                 goto_exec   = 1'b1;
        end
        OP_FINISH: begin
          if (count != CW'(1)) begin
            status_next = ST_FINISH_COUNT;
          end else begin
            finish_ok  = 1'b1;
            count_next = '0;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_top_next = finish_ok ? top : ((count_next != '0) ? top_next : '0);
  assign depth_ext    = {{DEPTH_W{1'b0}}, count_next};
  assign depth7_next  = depth_ext[DEPTH_W-1:0];
  assign count_ext    = {{DEPTH_W{1'b0}}, count};
  assign count7       = count_ext[DEPTH_W-1:0];

  // Sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (accept) state_next = goto_exec ? S_EXEC : S_RESP;
      S_EXEC: begin
        priority case (op)
          OP_MUL:  state_next = S_MUL;
          OP_DIV:  state_next = S_DIV;
          default: state_next = S_RESP;
        endcase
      end
      S_MUL:  if (iter == '0) state_next = S_RESP;
      S_DIV:  if (iter == '0) state_next = neg ? S_FIX : S_RESP;
      S_FIX:  state_next = S_RESP;
      S_RESP: if (m_axis_tready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  // Stack memory write: push at the count, write back over the second entry
  assign mem_we    = commit || (accept && (in_op == OP_PUSH) && !full);
  assign mem_widx  = commit ? rd_idx : count[AW-1:0];
  assign mem_wdata = commit ? res : in_val;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      stack_mem[mem_widx] <= mem_wdata;
    end
    mem_rd <= stack_mem[rd_idx];
  end

  // Datapath and result registers
  always_ff @(posedge clk) begin
    top <= top_next;
    if (accept) begin
      op <= in_op;
    end
    if ((state_next == S_RESP) && (state != S_RESP)) begin
      out_top    <= out_top_next;
      out_status <= status_next;
      out_depth  <= depth7_next;
    end
    unique case (state)
      S_EXEC: begin
        rem  <= '0;
        iter <= '1;
        if (op == OP_DIV) begin
          quo <= magnitude(mem_rd);
          den <= magnitude(top);
          neg <= mem_rd[DATA_W-1] ^ top[DATA_W-1];
        end else begin
          quo <= top;
          den <= mem_rd;
          neg <= 1'b0;
        end
      end
      S_MUL: begin
        rem  <= acc_step;
        den  <= {den[DATA_W-2:0], 1'b0};
        quo  <= {1'b0, quo[DATA_W-1:1]};
        iter <= iter - ITER_W'(1);
      end
      S_DIV: begin
        rem  <= rem_step;
        quo  <= quo_step;
        iter <= iter - ITER_W'(1);
      end
      default: ;
    endcase
  end

  `PSE_ASSERT_IMPLY(a_one_side_open, s_axis_tready, !m_axis_tvalid, "ready while result pending")
  `PSE_ASSERT_ALWAYS(a_count_range, count <= CW'(STACK_DEPTH), "stack count beyond depth")
  `PSE_ASSERT_IMPLY(a_depth_match, m_axis_tvalid, out_depth == count7, "depth_after mismatch")
  `PSE_ASSERT_NEXT(a_div_iterate, (state == S_DIV) && (iter != '0), state == S_DIV, "divide cut short")
  `PSE_ASSERT_NEXT(a_push_grows, accept && (in_op == OP_PUSH) && !full, count == $past(count) + CW'(1), "push lost")

endmodule
